@@ rtl/core/arr_pkg.sv @@
// Package for the address range registry: request, response and table entry
// types, kind and status codes, and sizing defaults.
// No dependencies.
package arr_pkg;

	localparam int ADDR_W      = 16;
	localparam int ENTRIES_DEF = 16;
	localparam int KIND_W      = 2;
	localparam int STATUS_W    = 3;
	localparam int LEVEL_W     = 2;
	localparam int TAG_W       = 16;
	localparam int HIT_IDX_W   = 4;
	localparam int COUNT_OUT_W = 5;

	// Request kinds
	localparam logic [KIND_W-1:0] KIND_INIT   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_REG    = 2'd2;
	localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd3;

	// Response status codes
	localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
	localparam logic [STATUS_W-1:0] ST_NOINIT   = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
	localparam logic [STATUS_W-1:0] ST_BADRANGE = 3'd3;
	localparam logic [STATUS_W-1:0] ST_OVERLAP  = 3'd4;
	localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd5;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [ADDR_W-1:0]  address_or_start;
		logic [ADDR_W-1:0]  range_end;
		logic [LEVEL_W-1:0] range_level;
		logic [TAG_W-1:0]   handler_tag;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0]    status;
		logic [HIT_IDX_W-1:0]   hit_index;
		logic [LEVEL_W-1:0]     hit_level;
		logic [TAG_W-1:0]       hit_tag;
		logic [COUNT_OUT_W-1:0] entry_count;
		logic [ADDR_W-1:0]      max_end;
	} rsp_t;

	typedef struct packed {
		logic [ADDR_W-1:0]  range_start;
		logic [ADDR_W-1:0]  range_last;
		logic [LEVEL_W-1:0] level;
		logic [TAG_W-1:0]   tag;
	} entry_t;

endpackage

@@ rtl/core/arr_table.sv @@
// Range table storage: one write port and one registered read port.
// Depends on arr_pkg for the entry type.
module arr_table #(
	parameter int ENTRIES = arr_pkg::ENTRIES_DEF,
	parameter int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
	input  logic                clk,
	input  logic                wr_en,
	input  logic [IDX_W-1:0]    wr_addr,
	input  arr_pkg::entry_t     wr_data,
	input  logic                rd_en,
	input  logic [IDX_W-1:0]    rd_addr,
	output arr_pkg::entry_t     rd_data
);

	arr_pkg::entry_t mem [ENTRIES];
	arr_pkg::entry_t rd_data_q;

	// Write one entry
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read one entry, registered
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ rtl/core/arr_cmp.sv @@
// Shared range comparator: tests a closed query range against one entry.
// A point lookup passes the same address as both query bounds.
// Depends on arr_pkg for widths.
module arr_cmp (
	input  logic [arr_pkg::ADDR_W-1:0] q_lo,
	input  logic [arr_pkg::ADDR_W-1:0] q_hi,
	input  logic [arr_pkg::ADDR_W-1:0] ent_lo,
	input  logic [arr_pkg::ADDR_W-1:0] ent_hi,
	output logic                       hit
);

	// Intersect when each start is at most the other's end
	assign hit = (q_lo <= ent_hi) && (q_hi >= ent_lo);

endmodule

@@ rtl/core/address_range_registry.sv @@
// Address range registry (arr_pkg, arr_table, arr_cmp), one request at a time.
// A request without a table scan goes from the idle state to the result state and is posted once
// the output is free; a scan compares one stored range per cycle and stops at the first hit.
// A new request is taken only after the result has moved to the output register, so later while
// an earlier result is still stalled at the output.
// Reset: table empty, not initialized, overlap check on; entries undefined until written.
module address_range_registry #(
	parameter int ENTRIES = arr_pkg::ENTRIES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  arr_pkg::req_t in_data,
	output logic          out_valid,
	input  logic          out_stall,
	output arr_pkg::rsp_t out_data,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic          cfg_data
);

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(ENTRIES);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_RESP
	} state_t;

	state_t                     state_q;
	logic                       init_q;
	logic                       chk_q;
	logic [CNT_W-1:0]           count_q;
	logic [arr_pkg::ADDR_W-1:0] max_end_q;
	arr_pkg::req_t              req_q;
	arr_pkg::rsp_t              res_q;
	arr_pkg::rsp_t              out_q;
	logic                       out_valid_q;
	logic [CNT_W-1:0]           issue_q;
	logic                       cmp_vld_s1;
	logic [IDX_W-1:0]           cmp_idx_s1;

	logic                       in_fire;
	logic                       scan_req;
	logic                       issuing;
	logic                       cmp_hit;
	logic                       scan_hit;
	logic                       scan_miss;
	logic                       commit_now;
	logic                       commit_scan;
	logic                       out_free;
	logic                       mem_we;
	arr_pkg::entry_t            mem_wdata;
	arr_pkg::entry_t            mem_rdata;
	logic [arr_pkg::ADDR_W-1:0] cmp_hi;
	logic [31:0]                count_ext;
	logic [31:0]                cnt_idx_ext;
	logic [31:0]                hit_idx_ext;

	// Handshake and scan control
	always_comb begin
		in_fire     = in_valid && (state_q == S_IDLE);
		scan_req    = in_fire && init_q && (count_q != '0)
			&& ((in_data.kind == arr_pkg::KIND_LOOKUP)
			|| ((in_data.kind == arr_pkg::KIND_REG) && (count_q < FULL_CNT)
			&& (in_data.address_or_start <= in_data.range_end) && chk_q));
		issuing     = (state_q == S_SCAN) && (issue_q < count_q);
		scan_hit    = (state_q == S_SCAN) && cmp_vld_s1 && cmp_hit;
		scan_miss   = (state_q == S_SCAN) && !cmp_vld_s1 && !issuing;
		commit_now  = in_fire && (in_data.kind == arr_pkg::KIND_REG) && init_q
			&& (count_q < FULL_CNT)
			&& (in_data.address_or_start <= in_data.range_end)
			&& !(chk_q && (count_q != '0));
		commit_scan = scan_miss && (req_q.kind == arr_pkg::KIND_REG);
		mem_we      = commit_now || commit_scan;
		out_free    = !out_valid_q || !out_stall;
		cmp_hi      = (req_q.kind == arr_pkg::KIND_LOOKUP) ? req_q.address_or_start
			: req_q.range_end;
		count_ext   = 32'(count_q);
		cnt_idx_ext = 32'(count_q);
		hit_idx_ext = 32'(cmp_idx_s1);
	end

	// Select the write entry: the new request or the one held during the scan
	always_comb begin
		if (commit_now) begin
			mem_wdata = '{range_start: in_data.address_or_start,
				range_last: in_data.range_end,
				level: in_data.range_level, tag: in_data.handler_tag};
		end else begin
			mem_wdata = '{range_start: req_q.address_or_start,
				range_last: req_q.range_end,
				level: req_q.range_level, tag: req_q.handler_tag};
		end
	end

	arr_table #(
		.ENTRIES (ENTRIES),
		.IDX_W   (IDX_W)
	) u_table (
		.clk     (clk),
		.wr_en   (mem_we),
		.wr_addr (count_q[IDX_W-1:0]),
		.wr_data (mem_wdata),
		.rd_en   (issuing),
		.rd_addr (issue_q[IDX_W-1:0]),
		.rd_data (mem_rdata)
	);

	arr_cmp u_cmp (
		.q_lo   (req_q.address_or_start),
		.q_hi   (cmp_hi),
		.ent_lo (mem_rdata.range_start),
		.ent_hi (mem_rdata.range_last),
		.hit    (cmp_hit)
	);

	// Sequencer, table bookkeeping and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			init_q      <= 1'b0;
			chk_q       <= 1'b1;
			count_q     <= '0;
			max_end_q   <= '0;
			req_q       <= '0;
			res_q       <= '0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
			issue_q     <= '0;
			cmp_vld_s1  <= 1'b0;
			cmp_idx_s1  <= '0;
		end else begin
			// Take configuration writes
			if (cfg_valid) begin
				chk_q <= cfg_data;
			end

			// Post a result, or drop one once taken
			if ((state_q == S_RESP) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						req_q   <= in_data;
						state_q <= scan_req ? S_SCAN : S_RESP;
						case (in_data.kind)
							arr_pkg::KIND_INIT: begin
								init_q    <= 1'b1;
								count_q   <= '0;
								max_end_q <= '0;
							end
							arr_pkg::KIND_CLEAR: begin
								count_q   <= '0;
								max_end_q <= '0;
							end
							arr_pkg::KIND_REG: begin
								if (!init_q) begin
									res_q.status <= arr_pkg::ST_NOINIT;
								end else if (count_q >= FULL_CNT) begin
									res_q.status <= arr_pkg::ST_FULL;
								end else if (in_data.address_or_start > in_data.range_end) begin
									res_q.status <= arr_pkg::ST_BADRANGE;
								end else if (chk_q && (count_q != '0)) begin
									issue_q    <= '0;
									cmp_vld_s1 <= 1'b0;
								end else begin
									res_q.hit_index <= cnt_idx_ext[arr_pkg::HIT_IDX_W-1:0];
									count_q         <= count_q + CNT_W'(1);
									if (in_data.range_end > max_end_q) begin
										max_end_q <= in_data.range_end;
									end
								end
							end
							arr_pkg::KIND_LOOKUP: begin
								if (!init_q) begin
									res_q.status <= arr_pkg::ST_NOINIT;
								end else if (count_q == '0) begin
									res_q.status <= arr_pkg::ST_NOTFOUND;
								end else begin
									issue_q    <= '0;
									cmp_vld_s1 <= 1'b0;
								end
							end
							default: begin
							end
						endcase
					end
				end

				S_SCAN: begin
					// Advance the read pointer and the compare stage
					issue_q    <= issue_q + CNT_W'(issuing);
					cmp_vld_s1 <= issuing;
					cmp_idx_s1 <= issue_q[IDX_W-1:0];
					if (scan_hit) begin
						state_q <= S_RESP;
						if (req_q.kind == arr_pkg::KIND_LOOKUP) begin
							res_q.status    <= arr_pkg::ST_OK;
							res_q.hit_index <= hit_idx_ext[arr_pkg::HIT_IDX_W-1:0];
							res_q.hit_level <= mem_rdata.level;
							res_q.hit_tag   <= mem_rdata.tag;
						end else begin
							res_q.status <= arr_pkg::ST_OVERLAP;
						end
					end else if (scan_miss) begin
						state_q <= S_RESP;
						if (req_q.kind == arr_pkg::KIND_LOOKUP) begin
							res_q.status <= arr_pkg::ST_NOTFOUND;
						end else begin
							res_q.status    <= arr_pkg::ST_OK;
							res_q.hit_index <= cnt_idx_ext[arr_pkg::HIT_IDX_W-1:0];
							count_q         <= count_q + CNT_W'(1);
							if (req_q.range_end > max_end_q) begin
								max_end_q <= req_q.range_end;
							end
						end
					end
				end

				S_RESP: begin
					// Hand the result to the output register and clear it for the next request
					if (out_free) begin
						out_q <= '{status: res_q.status, hit_index: res_q.hit_index,
							hit_level: res_q.hit_level, hit_tag: res_q.hit_tag,
							entry_count: count_ext[arr_pkg::COUNT_OUT_W-1:0],
							max_end: max_end_q};
						res_q   <= '0;
						state_q <= S_IDLE;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign cfg_ready = 1'b1;

`ifndef SYNTHESIS
	// Count never exceeds the table depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("entry count beyond table depth");

	// A table write only lands in a free slot
	a_write_free: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (count_q < FULL_CNT))
		else $error("table write with table full");

	// Count moves by one append or drops to empty
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |-> ((count_q == $past(count_q) + CNT_W'(1))
			|| (count_q == '0)))
		else $error("entry count jumped");

	// An empty table reports no largest end
	a_empty_max: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (max_end_q == '0))
		else $error("largest end nonzero on empty table");

	// Compared entries are always stored ones
	a_cmp_stored: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_SCAN) && cmp_vld_s1) |-> (CNT_W'(cmp_idx_s1) < count_q))
		else $error("compare of an unwritten entry");
`endif

endmodule

@@ tb/tb_address_range_registry.sv @@
// Self-checking testbench for address_range_registry: directed and random init, clear,
// register and lookup requests against a table predictor, with random request gaps and output stalls.
// Depends on arr_pkg and the address_range_registry RTL.
module tb_address_range_registry;

	localparam int N_ENTRIES   = arr_pkg::ENTRIES_DEF;
	localparam int STUCK_LIMIT = 2000;
	localparam int PHASE_ITEMS = 425;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic          in_valid  = 1'b0;
	logic          in_stall;
	arr_pkg::req_t in_data   = '0;
	logic          out_valid;
	logic          out_stall = 1'b0;
	arr_pkg::rsp_t out_data;
	logic          cfg_valid = 1'b0;
	logic          cfg_ready;
	logic          cfg_data  = 1'b0;

	// Requests waiting to be driven, and responses predicted but not yet seen
	arr_pkg::req_t req_backlog[$];
	arr_pkg::rsp_t awaited_rsps[$];

	// Predictor copy of the registry
	arr_pkg::entry_t stored_ranges [N_ENTRIES];
	int              range_count      = 0;
	logic            is_initialized   = 1'b0;
	logic [15:0]     top_end          = '0;
	logic            overlap_check_on = 1'b1;

	int            error_count  = 0;
	int            stuck_cycles = 0;
	int            calm_left    = 0;
	int            req_gap      = 0;
	int            stall_left   = 0;
	logic          req_taken    = 1'b0;
	arr_pkg::rsp_t want_rsp;

	address_range_registry #(
		.ENTRIES(N_ENTRIES)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	always #2 clk = ~clk;

	// Compute the response of one request and advance the predicted table
	function automatic arr_pkg::rsp_t predict_rsp(input arr_pkg::req_t r);
		arr_pkg::rsp_t rsp;
		logic clash;
		logic found;
		rsp   = '0;
		clash = 1'b0;
		found = 1'b0;
		case (r.kind)
			arr_pkg::KIND_INIT: begin
				is_initialized = 1'b1;
				range_count    = 0;
				top_end        = '0;
			end
			arr_pkg::KIND_CLEAR: begin
				range_count = 0;
				top_end     = '0;
			end
			arr_pkg::KIND_REG: begin
				if (!is_initialized) begin
					rsp.status = arr_pkg::ST_NOINIT;
				end else if (range_count >= N_ENTRIES) begin
					rsp.status = arr_pkg::ST_FULL;
				end else if (r.address_or_start > r.range_end) begin
					rsp.status = arr_pkg::ST_BADRANGE;
				end else begin
					if (overlap_check_on) begin
						for (int i = 0; i < range_count; i++) begin
							if (r.address_or_start <= stored_ranges[i].range_last &&
									r.range_end >= stored_ranges[i].range_start) begin
								clash = 1'b1;
							end
						end
					end
					if (clash) begin
						rsp.status = arr_pkg::ST_OVERLAP;
					end else begin
						rsp.status = arr_pkg::ST_OK;
						rsp.hit_index = 4'(range_count);
						stored_ranges[range_count].range_start = r.address_or_start;
						stored_ranges[range_count].range_last  = r.range_end;
						stored_ranges[range_count].level       = r.range_level;
						stored_ranges[range_count].tag         = r.handler_tag;
						range_count++;
						if (r.range_end > top_end) begin
							top_end = r.range_end;
						end
					end
				end
			end
			default: begin
				if (!is_initialized) begin
					rsp.status = arr_pkg::ST_NOINIT;
				end else begin
					rsp.status = arr_pkg::ST_NOTFOUND;
					// First hit in insertion order wins
					for (int i = 0; i < range_count && !found; i++) begin
						if (r.address_or_start >= stored_ranges[i].range_start &&
								r.address_or_start <= stored_ranges[i].range_last) begin
							found         = 1'b1;
							rsp.status    = arr_pkg::ST_OK;
							rsp.hit_index = 4'(i);
							rsp.hit_level = stored_ranges[i].level;
							rsp.hit_tag   = stored_ranges[i].tag;
						end
					end
				end
			end
		endcase
		rsp.entry_count = 5'(range_count);
		rsp.max_end     = top_end;
		return rsp;
	endfunction

	// Idle length: mostly none or short, a few long, none during a calm stretch
	function automatic int next_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm_left > 0 || r < 50) begin
			return 0;
		end else if (r < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [15:0] sat16(input int v);
		if (v < 0) begin
			return 16'd0;
		end else if (v > 65535) begin
			return 16'hFFFF;
		end
		return 16'(v);
	endfunction

	function automatic void push_req(input logic [1:0] kind, input logic [15:0] a,
			input logic [15:0] e, input logic [1:0] lvl, input logic [15:0] tag);
		arr_pkg::req_t r;
		r.kind             = kind;
		r.address_or_start = a;
		r.range_end        = e;
		r.range_level      = lvl;
		r.handler_tag      = tag;
		req_backlog.push_back(r);
	endfunction

	function automatic void push_random_of_kind(input logic [1:0] kind);
		push_req(kind, 16'($urandom), 16'($urandom), 2'($urandom), 16'($urandom));
	endfunction

	// Hold until every request is sent and every response has arrived
	task automatic wait_drained();
		while (req_backlog.size() != 0 || in_valid || awaited_rsps.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic write_overlap_check(input logic value);
		wait_drained();
		repeat (4) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Queue mostly init/register/lookup sequences around one address cluster, plus noise
	task automatic queue_random_traffic(input int n_items);
		int queued;
		int pick;
		int span;
		int lo;
		int hi;
		int tmp;
		int base;
		int lo_seen[$];
		int hi_seen[$];
		queued = 0;
		while (queued < n_items) begin
			if ($urandom_range(0, 9) == 0) begin
				push_random_of_kind(2'($urandom));
				queued++;
			end else begin
				lo_seen.delete();
				hi_seen.delete();
				pick = $urandom_range(0, 9);
				if (pick < 7) begin
					push_random_of_kind(arr_pkg::KIND_INIT);
					queued++;
				end else if (pick < 9) begin
					push_random_of_kind(arr_pkg::KIND_CLEAR);
					queued++;
				end
				base = $urandom_range(0, 65535);
				repeat ($urandom_range(1, 20)) begin
					pick = $urandom_range(0, 19);
					if (pick < 14) begin
						span = $urandom_range(0, 40);
					end else if (pick < 18) begin
						span = $urandom_range(0, 4000);
					end else if (pick == 18) begin
						span = 0;
					end else begin
						span = 65535;
					end
					if ($urandom_range(0, 5) == 0) begin
						lo = $urandom_range(0, 65535);
					end else begin
						lo = base + $urandom_range(0, 600);
					end
					if ($urandom_range(0, 30) == 0) begin
						lo = 0;
					end
					if (lo > 65535) begin
						lo = 65535 - $urandom_range(0, 50);
					end
					hi = lo + span;
					if (hi > 65535) begin
						hi = 65535;
					end
					// Swap now and then to get a start above the end
					if ($urandom_range(0, 15) == 0 && lo != hi) begin
						tmp = lo;
						lo  = hi;
						hi  = tmp;
					end
					lo_seen.push_back(lo);
					hi_seen.push_back(hi);
					push_req(arr_pkg::KIND_REG, 16'(lo), 16'(hi), 2'($urandom), 16'($urandom));
					queued++;
				end
				repeat ($urandom_range(1, 12)) begin
					pick = $urandom_range(0, lo_seen.size() - 1);
					lo   = lo_seen[pick];
					hi   = hi_seen[pick];
					case ($urandom_range(0, 5))
						0:       tmp = lo;
						1:       tmp = hi;
						2:       tmp = lo - 1;
						3:       tmp = hi + 1;
						4:       tmp = $urandom_range(lo, hi);
						default: tmp = $urandom_range(0, 65535);
					endcase
					push_req(arr_pkg::KIND_LOOKUP, sat16(tmp), 16'($urandom), 2'($urandom),
						16'($urandom));
					queued++;
				end
			end
		end
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			error_count++;
		end
	endtask

	// Drive requests at the falling edge; start a new gap after each accepted request
	always @(negedge clk) begin
		if (arst_n && (req_taken || !in_valid)) begin
			if (req_taken) begin
				req_gap = next_gap();
			end
			if (req_gap > 0) begin
				req_gap--;
				in_valid <= 1'b0;
			end else if (req_backlog.size() > 0) begin
				in_data  <= req_backlog.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Stall the response side in random bursts
	always @(negedge clk) begin
		if (stall_left == 0 && $urandom_range(0, 3) == 0) begin
			stall_left = next_gap();
		end
		if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Sample handshakes at the rising edge: check responses, predict requests, track config
	always @(posedge clk) begin
		req_taken <= in_valid && !in_stall;
		if (calm_left > 0) begin
			calm_left--;
		end else if ($urandom_range(0, 499) == 0) begin
			calm_left = $urandom_range(50, 300);
		end
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
			stuck_cycles = 0;
		end else begin
			stuck_cycles++;
		end
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (awaited_rsps.size() == 0) begin
					$error("response with none awaited: %p", out_data);
					error_count++;
				end else begin
					want_rsp = awaited_rsps.pop_front();
					check_field("status", want_rsp.status, out_data.status);
					check_field("hit_index", want_rsp.hit_index, out_data.hit_index);
					check_field("hit_level", want_rsp.hit_level, out_data.hit_level);
					check_field("hit_tag", want_rsp.hit_tag, out_data.hit_tag);
					check_field("entry_count", want_rsp.entry_count, out_data.entry_count);
					check_field("max_end", want_rsp.max_end, out_data.max_end);
				end
			end
			if (in_valid && !in_stall) begin
				awaited_rsps.push_back(predict_rsp(in_data));
			end
			if (cfg_valid && cfg_ready) begin
				overlap_check_on = cfg_data;
			end
		end
	end

	// End the run when nothing moves for too long
	initial begin
		while (stuck_cycles < STUCK_LIMIT) begin
			@(posedge clk);
		end
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Before init, then edges of the address space, bad range, overlap and miss
		push_req(arr_pkg::KIND_LOOKUP, 16'h0000, 16'hFFFF, 2'd3, 16'hFFFF);
		push_req(arr_pkg::KIND_REG,    16'h000A, 16'h0014, 2'd1, 16'h1234);
		push_req(arr_pkg::KIND_CLEAR,  16'hFFFF, 16'hFFFF, 2'd3, 16'hFFFF);
		push_req(arr_pkg::KIND_LOOKUP, 16'hFFFF, 16'h0000, 2'd0, 16'h0000);
		push_req(arr_pkg::KIND_INIT,   16'h0000, 16'h0000, 2'd0, 16'h0000);
		push_req(arr_pkg::KIND_LOOKUP, 16'h8000, 16'h8000, 2'd0, 16'h0000);
		push_req(arr_pkg::KIND_REG,    16'h0000, 16'h0000, 2'd3, 16'hFFFF);
		push_req(arr_pkg::KIND_REG,    16'hFFFF, 16'hFFFF, 2'd0, 16'h0000);
		push_req(arr_pkg::KIND_REG,    16'h0005, 16'h0004, 2'd1, 16'h0001);
		push_req(arr_pkg::KIND_REG,    16'h0000, 16'h0010, 2'd2, 16'h0002);
		push_req(arr_pkg::KIND_REG,    16'hFFF0, 16'hFFFF, 2'd2, 16'h0003);
		push_req(arr_pkg::KIND_REG,    16'h0100, 16'h01FF, 2'd2, 16'hA5A5);
		push_req(arr_pkg::KIND_LOOKUP, 16'h0000, 16'h0000, 2'd0, 16'h0000);
		push_req(arr_pkg::KIND_LOOKUP, 16'hFFFF, 16'h0000, 2'd0, 16'h0000);
		push_req(arr_pkg::KIND_LOOKUP, 16'h00FF, 16'h0000, 2'd0, 16'h0000);
		push_req(arr_pkg::KIND_LOOKUP, 16'h01FF, 16'h0000, 2'd0, 16'h0000);
		push_req(arr_pkg::KIND_LOOKUP, 16'h0200, 16'h0000, 2'd0, 16'h0000);
		push_req(arr_pkg::KIND_REG,    16'h01FF, 16'h0300, 2'd1, 16'h0004);
		push_req(arr_pkg::KIND_REG,    16'h0200, 16'h0300, 2'd1, 16'h5A5A);
		push_req(arr_pkg::KIND_CLEAR,  16'h0000, 16'h0000, 2'd0, 16'h0000);
		push_req(arr_pkg::KIND_LOOKUP, 16'h0000, 16'h0000, 2'd0, 16'h0000);
		push_req(arr_pkg::KIND_INIT,   16'hFFFF, 16'hFFFF, 2'd3, 16'hFFFF);

		// With the overlap check off, identical ranges stack and lookup takes the first
		write_overlap_check(1'b0);
		push_req(arr_pkg::KIND_REG,    16'h0000, 16'hFFFF, 2'd1, 16'h1111);
		push_req(arr_pkg::KIND_REG,    16'h0000, 16'hFFFF, 2'd2, 16'h2222);
		push_req(arr_pkg::KIND_LOOKUP, 16'h1234, 16'h0000, 2'd0, 16'h0000);

		queue_random_traffic(PHASE_ITEMS);
		write_overlap_check(1'b1);
		queue_random_traffic(PHASE_ITEMS);
		write_overlap_check(1'b0);
		queue_random_traffic(PHASE_ITEMS);
		write_overlap_check(1'b1);
		queue_random_traffic(PHASE_ITEMS);

		wait_drained();
		repeat (40) @(posedge clk);
		if (error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
